@@ hw/rtl/hwvj_pkg.sv @@
`default_nettype none
package hwvj_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;

    localparam int XW      = 34;
    localparam int ZW      = 33;
    localparam int SW      = 18;
    localparam int NW      = 53;
    localparam int DW      = 40;
    localparam int RW      = 58;
    localparam int Q_BITS  = 17;
    localparam int DIV_LAT = Q_BITS + 2;
    localparam int BACK_LAT = CORDIC_STAGES + 5 + DIV_LAT;

    localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);

    typedef enum logic [2:0] {
        REG_DIM_A     = 3'd0,
        REG_DIM_B     = 3'd1,
        REG_DIM_R     = 3'd2,
        REG_TARGET_VX = 3'd3,
        REG_TARGET_VY = 3'd4,
        REG_TARGET_VR = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] z;
        logic               neg;
    } item_t;

    typedef struct packed {
        logic        [15:0] dim_a;
        logic        [15:0] dim_b;
        logic        [15:0] dim_r;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vr;
    } cfg_t;

    function automatic logic [31:0] turn_atan(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hwvj_front.sv @@
`default_nettype none
module hwvj_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [15:0]   heading,
    output logic               f_valid,
    input  wire logic          f_ready,
    output hwvj_pkg::item_t    f_item
);
    import hwvj_pkg::*;

    localparam int DN = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam logic [15:0] HMASK = 16'(16'hFFFF << DN);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic [31:0] turn;

    assign in_ready = !valid_reg || f_ready;
    assign f_valid  = valid_reg;
    assign f_item   = item_reg;

    always_comb
    begin
        turn = {heading & HMASK, 16'h0000};
        item_next.neg = ($signed(turn) > 32'sd1073741824) ||
                        ($signed(turn) < -32'sd1073741824);
        item_next.z = item_next.neg ? $signed({~turn[31], turn[30:0]}) : $signed(turn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (f_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/hwvj_queue.sv @@
`default_nettype none
module hwvj_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire hwvj_pkg::item_t in_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output hwvj_pkg::item_t    out_item
);
    import hwvj_pkg::*;

    item_t mem [0:1];
    logic [1:0] count_reg;
    logic       wr_reg;
    logic       rd_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_item;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/hwvj_div.sv @@
`default_nettype none
module hwvj_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [hwvj_pkg::NW-1:0] num,
    input  wire logic        [hwvj_pkg::DW-1:0] den,
    input  wire logic signed [15:0]            off,
    output logic signed [15:0]                 res,
    output logic                               clip
);
    import hwvj_pkg::*;

    logic [RW-1:0]     rem_reg  [0:Q_BITS];
    logic [Q_BITS-1:0] q_reg    [0:Q_BITS];
    logic              ovf_reg  [0:Q_BITS];
    logic              sign_reg [0:Q_BITS];
    logic signed [15:0] res_reg;
    logic               clip_reg;

    logic [NW:0]   mag;
    logic [RW-1:0] bias;
    logic signed [19:0] qs;
    logic signed [19:0] v;

    assign res  = res_reg;
    assign clip = clip_reg;

    always_comb
    begin
        mag  = num[NW-1] ? (NW+1)'(-((NW+1)'(num))) : (NW+1)'(num);
        bias = RW'(mag) + RW'(den >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= bias;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= (bias >= (RW'(den) << Q_BITS));
            sign_reg[0] <= num[NW-1];
        end
    end

    for (genvar k = 1; k <= Q_BITS; k++)
    begin : g_step
        logic [RW-1:0] dsh;
        logic          ge;
        assign dsh = RW'(den) << (Q_BITS - k);
        assign ge  = (rem_reg[k-1] >= dsh);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? rem_reg[k-1] - dsh : rem_reg[k-1];
                q_reg[k]    <= q_reg[k-1] | (Q_BITS'(ge) << (Q_BITS - k));
                ovf_reg[k]  <= ovf_reg[k-1];
                sign_reg[k] <= sign_reg[k-1];
            end
        end
    end

    always_comb
    begin
        qs = sign_reg[Q_BITS] ? -(20'(q_reg[Q_BITS])) : 20'(q_reg[Q_BITS]);
        v  = qs - 20'(off);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ovf_reg[Q_BITS])
            begin
                res_reg  <= sign_reg[Q_BITS] ? -16'sd32768 : 16'sd32767;
                clip_reg <= 1'b1;
            end
            else if (v > 20'sd32767)
            begin
                res_reg  <= 16'sd32767;
                clip_reg <= 1'b1;
            end
            else if (v < -20'sd32768)
            begin
                res_reg  <= -16'sd32768;
                clip_reg <= 1'b1;
            end
            else
            begin
                res_reg  <= v[15:0];
                clip_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/hwvj_back.sv @@
`default_nettype none
module hwvj_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hwvj_pkg::cfg_t   cfg,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire hwvj_pkg::item_t  q_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic signed [15:0]    wheel_one,
    output logic signed [15:0]    wheel_two,
    output logic signed [15:0]    turret_rate,
    output logic                  clipped
);
    import hwvj_pkg::*;

    function automatic logic signed [SW-1:0] round15(input logic signed [XW-1:0] v);
        logic [XW-1:0] m;
        logic [XW-1:0] r;
        m = v[XW-1] ? XW'(-v) : XW'(v);
        r = (m + XW'(16384)) >> 15;
        return v[XW-1] ? -($signed(r[SW-1:0])) : $signed(r[SW-1:0]);
    endfunction

    logic en;
    logic [BACK_LAT-1:0] vld_reg;

    logic signed [XW-1:0] x_reg [0:CORDIC_STAGES-1];
    logic signed [XW-1:0] y_reg [0:CORDIC_STAGES-1];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STAGES-1];
    logic                 n_reg [0:CORDIC_STAGES-1];

    logic signed [SW-1:0] s_reg, c_reg;
    logic signed [34:0] bs_reg, ac_reg, bc_reg, as_reg;
    logic signed [33:0] vxc_reg, vys_reg;
    logic signed [35:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [34:0] nt_reg;
    logic signed [51:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [34:0] nt2_reg;
    logic signed [NW-1:0] n1_reg, n2_reg, nt3_reg;
    logic [31:0] rb_reg;

    logic [15:0] bd;
    logic [15:0] rd;
    logic [DW-1:0] dw;
    logic [DW-1:0] dt;
    logic signed [XW-1:0] xn, yn;
    logic clip1, clip2, clip3;

    assign en      = !vld_reg[BACK_LAT-1] || out_ready;
    assign q_ready = en;
    assign out_valid = vld_reg[BACK_LAT-1];
    assign clipped = clip1 || clip2 || clip3;

    assign bd = (cfg.dim_b == 16'd0) ? 16'd1 : cfg.dim_b;
    assign rd = (cfg.dim_r == 16'd0) ? 16'd1 : cfg.dim_r;
    assign dw = DW'({rb_reg, 7'b0});
    assign dt = DW'({bd, 7'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[BACK_LAT-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rb_reg <= 32'(bd) * 32'(rd);
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        logic signed [XW-1:0] xi, yi;
        logic signed [ZW-1:0] zi;
        logic                 ni;
        if (i == 0)
        begin : g_first
            assign xi = CORDIC_X0;
            assign yi = '0;
            assign zi = ZW'(q_item.z);
            assign ni = q_item.neg;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign ni = n_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[ZW-1])
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - $signed(ZW'(turn_atan(i)));
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + $signed(ZW'(turn_atan(i)));
                end
                n_reg[i] <= ni;
            end
        end
    end

    always_comb
    begin
        xn = n_reg[CORDIC_STAGES-1] ? -x_reg[CORDIC_STAGES-1] : x_reg[CORDIC_STAGES-1];
        yn = n_reg[CORDIC_STAGES-1] ? -y_reg[CORDIC_STAGES-1] : y_reg[CORDIC_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= round15(xn);
            s_reg <= round15(yn);

            bs_reg  <= 35'($signed({1'b0, bd})) * 35'(s_reg);
            ac_reg  <= 35'($signed({1'b0, cfg.dim_a})) * 35'(c_reg);
            bc_reg  <= 35'($signed({1'b0, bd})) * 35'(c_reg);
            as_reg  <= 35'($signed({1'b0, cfg.dim_a})) * 35'(s_reg);
            vxc_reg <= 34'(cfg.vx) * 34'(c_reg);
            vys_reg <= 34'(cfg.vy) * 34'(s_reg);

            p1_reg <= -36'(bs_reg) - 36'(ac_reg);
            p2_reg <= 36'(bc_reg) - 36'(as_reg);
            p3_reg <= -36'(bs_reg) + 36'(ac_reg);
            p4_reg <= 36'(bc_reg) + 36'(as_reg);
            nt_reg <= -35'(vxc_reg) - 35'(vys_reg);

            m1_reg  <= 52'(cfg.vx) * 52'(p1_reg);
            m2_reg  <= 52'(cfg.vy) * 52'(p2_reg);
            m3_reg  <= 52'(cfg.vx) * 52'(p3_reg);
            m4_reg  <= 52'(cfg.vy) * 52'(p4_reg);
            nt2_reg <= nt_reg;

            n1_reg  <= NW'(m1_reg) + NW'(m2_reg);
            n2_reg  <= NW'(m3_reg) + NW'(m4_reg);
            nt3_reg <= NW'(nt2_reg);
        end
    end

    hwvj_div u_div_one (
        .clk  (clk),
        .en   (en),
        .num  (n1_reg),
        .den  (dw),
        .off  (16'sd0),
        .res  (wheel_one),
        .clip (clip1)
    );

    hwvj_div u_div_two (
        .clk  (clk),
        .en   (en),
        .num  (n2_reg),
        .den  (dw),
        .off  (16'sd0),
        .res  (wheel_two),
        .clip (clip2)
    );

    hwvj_div u_div_turret (
        .clk  (clk),
        .en   (en),
        .num  (nt3_reg),
        .den  (dt),
        .off  (cfg.vr),
        .res  (turret_rate),
        .clip (clip3)
    );
endmodule
`default_nettype wire

@@ hw/rtl/holonomic_wheel_velocity_jacobian.sv @@
// Path: input register, queue, then CORDIC_STAGES + 24 back stages to result
// valid, with the default of 16 CORDIC stages.
// Throughput: one transaction per cycle unless the output stalls; the pipelined
// CORDIC and the one-quotient-bit-per-stage divider lanes set the depth.
// Reset: configuration returns to a = b = r = 1.0, setpoints 0; pipeline empties.
`default_nettype none
module holonomic_wheel_velocity_jacobian (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [15:0]        heading,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      wheel_one,
    output logic signed [15:0]      wheel_two,
    output logic signed [15:0]      turret_rate,
    output logic                    clipped
);
    import hwvj_pkg::*;

    cfg_t  cfg_reg;
    logic  f_valid, f_ready;
    item_t f_item;
    logic  q_valid, q_ready;
    item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_a <= 16'd256;
            cfg_reg.dim_b <= 16'd256;
            cfg_reg.dim_r <= 16'd256;
            cfg_reg.vx    <= 16'sd0;
            cfg_reg.vy    <= 16'sd0;
            cfg_reg.vr    <= 16'sd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIM_A:     cfg_reg.dim_a <= cfg_data;
                REG_DIM_B:     cfg_reg.dim_b <= cfg_data;
                REG_DIM_R:     cfg_reg.dim_r <= cfg_data;
                REG_TARGET_VX: cfg_reg.vx    <= $signed(cfg_data);
                REG_TARGET_VY: cfg_reg.vy    <= $signed(cfg_data);
                REG_TARGET_VR: cfg_reg.vr    <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    hwvj_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .heading  (heading),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_item   (f_item)
    );

    hwvj_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    hwvj_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .wheel_one   (wheel_one),
        .wheel_two   (wheel_two),
        .turret_rate (turret_rate),
        .clipped     (clipped)
    );

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid)
        else $error("front dropped a pending transaction");

    a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        !f_ready |-> q_valid)
        else $error("queue full but empty");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !out_ready && q_valid && q_ready))
        else $error("queue popped while output stalled");
endmodule
`default_nettype wire
